// ===== src/ssrb_pkg.sv =====
// Shared types and constants of the smoothstep start-ramp blend.
package ssrb_pkg;

    localparam int FRAC_BITS = 16;

    localparam int MAG_W = 39;
    localparam logic [MAG_W-1:0] TERM_LIMIT = '1;

    localparam int XDIV_STEPS = 32;
    localparam int DIV_LAT = MAG_W + 1;
    localparam int DIV_LEVELS = 3;

    localparam int CW = 44;
    localparam int VW = 33;
    localparam int PH_W = 46;
    localparam int SUM_W = MAG_W + 3;

    localparam int IDX_POLY = XDIV_STEPS + 5;
    localparam int IDX_SIGNED = IDX_POLY + 4 + DIV_LEVELS * DIV_LAT + 1;
    localparam int IDX_SUM = IDX_SIGNED + 1;
    localparam int CTX_N = IDX_SUM + 1;

    localparam int NUM_LANES = 10;
    localparam int LN_POS0 = 0;
    localparam int LN_VEL0 = 1;
    localparam int LN_VEL1 = 2;
    localparam int LN_ACC0 = 3;
    localparam int LN_ACC1 = 4;
    localparam int LN_ACC2 = 5;
    localparam int LN_JRK0 = 6;
    localparam int LN_JRK1 = 7;
    localparam int LN_JRK2 = 8;
    localparam int LN_JRK3 = 9;
    localparam int LANE_DIVS [NUM_LANES] = '{0, 0, 1, 0, 1, 2, 0, 1, 2, 3};

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_DURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAKEOFF_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAKEOFF_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAKEOFF_Z = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [31:0] RAMP_DURATION_RESET = 32'd2 << FRAC_BITS;
    localparam logic [31:0] TAKEOFF_Z_RESET = 32'd1 << FRAC_BITS;

    typedef struct packed {
        logic [31:0]        since_start;
        logic [1:0]         axis;
        logic signed [31:0] nominal_pos;
        logic signed [31:0] nominal_vel;
        logic signed [31:0] nominal_acc;
        logic signed [31:0] nominal_jerk;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_pos;
        logic signed [31:0] out_vel;
        logic signed [31:0] out_acc;
        logic signed [31:0] out_jerk;
        logic               ramp_active;
    } result_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } term_t;

endpackage

// ===== src/ssrb_div.sv =====
// Pipelined restoring divider: saturated (mag << FRAC_BITS) / dur, one quotient bit per stage.
module ssrb_div (
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         dur,
    input  ssrb_pkg::term_t     dividend,
    output ssrb_pkg::term_t     quotient
);

    localparam int MW = ssrb_pkg::MAG_W;
    localparam int F = ssrb_pkg::FRAC_BITS;

    logic [31:0]   rem_reg [MW];
    logic [MW-1:0] lo_reg [MW];
    logic [MW-1:0] q_reg [MW+1];
    logic          ovf_reg [MW+1];
    logic          neg_reg [MW+1];

    logic [32:0]   r2 [MW];
    logic [32:0]   sub [MW];
    logic          ge [MW];

    always_comb
    begin
        for (int j = 0; j < MW; j++)
        begin
            r2[j] = {rem_reg[j], lo_reg[j][MW-1]};
            sub[j] = r2[j] - {1'b0, dur};
            ge[j] = r2[j] >= {1'b0, dur};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {{(32-F){1'b0}}, dividend.mag[MW-1 -: F]};
            lo_reg[0] <= {dividend.mag[MW-F-1:0], {F{1'b0}}};
            q_reg[0] <= '0;
            ovf_reg[0] <= {{(32-F){1'b0}}, dividend.mag[MW-1 -: F]} >= dur;
            neg_reg[0] <= dividend.neg;
            for (int j = 0; j < MW; j++)
            begin
                q_reg[j+1] <= {q_reg[j][MW-2:0], ge[j]};
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
            for (int j = 0; j < MW - 1; j++)
            begin
                rem_reg[j+1] <= ge[j] ? sub[j][31:0] : r2[j][31:0];
                lo_reg[j+1] <= lo_reg[j] << 1;
            end
        end
    end

    assign quotient.neg = neg_reg[MW];
    assign quotient.mag = ovf_reg[MW] ? ssrb_pkg::TERM_LIMIT : q_reg[MW];

endmodule

// ===== src/smoothstep_start_ramp_blend.sv =====
// Top level of the quintic smoothstep start-ramp blend pipeline.
//
//   Channel   Direction  Handshake                    Payload
//   item      in         item_valid / item_ready      ssrb_pkg::item_t
//   result    out        result_valid / result_ready  ssrb_pkg::result_t
//   cfg       in         cfg_we                       cfg_index, cfg_data
//
// One item is accepted every cycle unless a held result stalls the pipeline.
// The pipeline depth is set by the 32-step quotient for t/T, four power multiplies, and three
// chained 40-step dividers by the ramp duration on the jerk path.
// Reset clears the valid bits and loads the register reset values.
// A held result freezes the whole pipeline; an empty first stage still takes one item.
module smoothstep_start_ramp_blend (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  ssrb_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output ssrb_pkg::result_t                    result,
    input  logic                                 cfg_we,
    input  logic [ssrb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data
);

    localparam int NL = ssrb_pkg::NUM_LANES;
    localparam int CW = ssrb_pkg::CW;
    localparam int VW = ssrb_pkg::VW;
    localparam int MW = ssrb_pkg::MAG_W;
    localparam int SW = ssrb_pkg::SUM_W;
    localparam int PW = ssrb_pkg::PH_W;
    localparam int XS = ssrb_pkg::XDIV_STEPS;
    localparam int CN = ssrb_pkg::CTX_N;
    localparam logic signed [CW-1:0] S3_BIAS = CW'(60) << 32;

    typedef struct packed {
        logic               active;
        logic signed [31:0] tk;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic signed [31:0] jerk;
    } ctx_t;

    function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[63:32];
    endfunction

    function automatic logic signed [CW-1:0] ext(input logic [31:0] v);
        return $signed({{(CW-32){1'b0}}, v});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        if (v > $signed({{(SW-32){1'b0}}, 32'h7fffffff}))
        begin
            return 32'sh7fffffff;
        end
        else if (v < $signed({{(SW-32){1'b1}}, 32'h80000000}))
        begin
            return 32'sh80000000;
        end
        else
        begin
            return v[31:0];
        end
    endfunction

    logic [31:0]        ramp_duration_reg;
    logic signed [31:0] takeoff_x_reg;
    logic signed [31:0] takeoff_y_reg;
    logic signed [31:0] takeoff_z_reg;

    logic               adv;
    logic               load;
    logic signed [31:0] tk_sel;

    logic [CN-1:0]      vld_reg;
    ctx_t               ctx_reg [CN];

    logic [31:0]        xrem_reg [XS];
    logic [31:0]        xq_reg [XS+1];
    logic [32:0]        xr2 [XS];
    logic [32:0]        xsub [XS];
    logic               xge [XS];

    logic [31:0] x_a_reg, x2_a_reg;
    logic [31:0] x_b_reg, x2_b_reg, x3_b_reg;
    logic [31:0] x_c_reg, x2_c_reg, x3_c_reg, x4_c_reg;
    logic [31:0] x_d_reg, x2_d_reg, x3_d_reg, x4_d_reg, x5_d_reg;

    logic signed [CW-1:0] s0_reg, s1_reg, s2_reg, s3_reg;
    logic signed [CW-1:0] s1x2, s1x3, s2x3;
    logic signed [VW-1:0] dp;

    logic signed [CW-1:0] lc_reg [NL];
    logic signed [VW-1:0] lv_reg [NL];
    logic [CW-1:0]        ua_reg [NL];
    logic [VW-1:0]        ub_reg [NL];
    logic                 ng_m_reg [NL];
    logic [PW-1:0]        ph_reg [NL];
    logic [31:0]          pl_reg [NL];
    logic                 ng_p_reg [NL];
    logic [63:0]          pl_full [NL];
    logic [PW-1:0]        rsum [NL];
    ssrb_pkg::term_t      term_reg [NL];
    ssrb_pkg::term_t      lvl [ssrb_pkg::DIV_LEVELS+1][NL];
    logic signed [MW:0]   sv_reg [NL];

    logic signed [SW-1:0] pos_sum_reg, vel_sum_reg, acc_sum_reg, jerk_sum_reg;

    logic                 result_valid_reg;
    ssrb_pkg::result_t    result_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_duration_reg <= ssrb_pkg::RAMP_DURATION_RESET;
            takeoff_x_reg <= '0;
            takeoff_y_reg <= '0;
            takeoff_z_reg <= ssrb_pkg::TAKEOFF_Z_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssrb_pkg::REG_RAMP_DURATION: ramp_duration_reg <= cfg_data;
                ssrb_pkg::REG_TAKEOFF_X:     takeoff_x_reg <= cfg_data;
                ssrb_pkg::REG_TAKEOFF_Y:     takeoff_y_reg <= cfg_data;
                ssrb_pkg::REG_TAKEOFF_Z:     takeoff_z_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign adv = !result_valid_reg || result_ready;
    assign load = adv || !vld_reg[0];
    assign item_ready = load;

    always_comb
    begin
        case (item.axis)
            ssrb_pkg::AXIS_X: tk_sel = takeoff_x_reg;
            ssrb_pkg::AXIS_Y: tk_sel = takeoff_y_reg;
            ssrb_pkg::AXIS_Z: tk_sel = takeoff_z_reg;
            default:          tk_sel = '0;
        endcase
    end

    // Valid bits and item context travel together down the whole pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                vld_reg[0] <= item_valid;
            end
            if (adv)
            begin
                vld_reg[CN-1:1] <= vld_reg[CN-2:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctx_reg[0].active <= (ramp_duration_reg != '0)
                && (item.since_start < ramp_duration_reg);
            ctx_reg[0].tk <= tk_sel;
            ctx_reg[0].pos <= item.nominal_pos;
            ctx_reg[0].vel <= item.nominal_vel;
            ctx_reg[0].acc <= item.nominal_acc;
            ctx_reg[0].jerk <= item.nominal_jerk;
            xrem_reg[0] <= item.since_start;
            xq_reg[0] <= '0;
        end
        if (adv)
        begin
            for (int k = 1; k < CN; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    // Normalized time x = t * 2^32 / T, one quotient bit per stage.
    always_comb
    begin
        for (int j = 0; j < XS; j++)
        begin
            xr2[j] = {xrem_reg[j], 1'b0};
            xsub[j] = xr2[j] - {1'b0, ramp_duration_reg};
            xge[j] = xr2[j] >= {1'b0, ramp_duration_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < XS; j++)
            begin
                xq_reg[j+1] <= {xq_reg[j][30:0], xge[j]};
            end
            for (int j = 0; j < XS - 1; j++)
            begin
                xrem_reg[j+1] <= xge[j] ? xsub[j][31:0] : xr2[j][31:0];
            end
        end
    end

    // Powers of x, one multiply per stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_a_reg <= xq_reg[XS];
            x2_a_reg <= qmul(xq_reg[XS], xq_reg[XS]);
            x_b_reg <= x_a_reg;
            x2_b_reg <= x2_a_reg;
            x3_b_reg <= qmul(x2_a_reg, x_a_reg);
            x_c_reg <= x_b_reg;
            x2_c_reg <= x2_b_reg;
            x3_c_reg <= x3_b_reg;
            x4_c_reg <= qmul(x3_b_reg, x_b_reg);
            x_d_reg <= x_c_reg;
            x2_d_reg <= x2_c_reg;
            x3_d_reg <= x3_c_reg;
            x4_d_reg <= x4_c_reg;
            x5_d_reg <= qmul(x4_c_reg, x_c_reg);
        end
    end

    // Smoothstep and its derivatives in Q.32.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= 10 * ext(x3_d_reg) - 15 * ext(x4_d_reg) + 6 * ext(x5_d_reg);
            s1_reg <= 30 * ext(x2_d_reg) - 60 * ext(x3_d_reg) + 30 * ext(x4_d_reg);
            s2_reg <= 60 * ext(x_d_reg) - 180 * ext(x2_d_reg) + 120 * ext(x3_d_reg);
            s3_reg <= S3_BIAS - 360 * ext(x_d_reg) + 360 * ext(x2_d_reg);
        end
    end

    always_comb
    begin
        s1x2 = s1_reg <<< 1;
        s1x3 = s1_reg + s1x2;
        s2x3 = s2_reg + (s2_reg <<< 1);
        dp = VW'(ctx_reg[ssrb_pkg::IDX_POLY].pos) - VW'(ctx_reg[ssrb_pkg::IDX_POLY].tk);
    end

    // Each lane is one coefficient times one value of the item.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lc_reg[ssrb_pkg::LN_POS0] <= s0_reg;
            lv_reg[ssrb_pkg::LN_POS0] <= dp;
            lc_reg[ssrb_pkg::LN_VEL0] <= s0_reg;
            lv_reg[ssrb_pkg::LN_VEL0] <= VW'(ctx_reg[ssrb_pkg::IDX_POLY].vel);
            lc_reg[ssrb_pkg::LN_VEL1] <= s1_reg;
            lv_reg[ssrb_pkg::LN_VEL1] <= dp;
            lc_reg[ssrb_pkg::LN_ACC0] <= s0_reg;
            lv_reg[ssrb_pkg::LN_ACC0] <= VW'(ctx_reg[ssrb_pkg::IDX_POLY].acc);
            lc_reg[ssrb_pkg::LN_ACC1] <= s1x2;
            lv_reg[ssrb_pkg::LN_ACC1] <= VW'(ctx_reg[ssrb_pkg::IDX_POLY].vel);
            lc_reg[ssrb_pkg::LN_ACC2] <= s2_reg;
            lv_reg[ssrb_pkg::LN_ACC2] <= dp;
            lc_reg[ssrb_pkg::LN_JRK0] <= s0_reg;
            lv_reg[ssrb_pkg::LN_JRK0] <= VW'(ctx_reg[ssrb_pkg::IDX_POLY].jerk);
            lc_reg[ssrb_pkg::LN_JRK1] <= s1x3;
            lv_reg[ssrb_pkg::LN_JRK1] <= VW'(ctx_reg[ssrb_pkg::IDX_POLY].acc);
            lc_reg[ssrb_pkg::LN_JRK2] <= s2x3;
            lv_reg[ssrb_pkg::LN_JRK2] <= VW'(ctx_reg[ssrb_pkg::IDX_POLY].vel);
            lc_reg[ssrb_pkg::LN_JRK3] <= s3_reg;
            lv_reg[ssrb_pkg::LN_JRK3] <= dp;
        end
    end

    // Sign-magnitude product, split so that no multiplier exceeds 32 by 33 bits.
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            pl_full[i] = 64'(ua_reg[i][31:0]) * 64'(ub_reg[i][31:0]);
            rsum[i] = ph_reg[i] + PW'(pl_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NL; i++)
            begin
                ua_reg[i] <= lc_reg[i][CW-1] ? CW'(-lc_reg[i]) : CW'(lc_reg[i]);
                ub_reg[i] <= lv_reg[i][VW-1] ? VW'(-lv_reg[i]) : VW'(lv_reg[i]);
                ng_m_reg[i] <= lc_reg[i][CW-1] ^ lv_reg[i][VW-1];
                ph_reg[i] <= PW'(ua_reg[i][CW-1:32] * ub_reg[i])
                    + (ub_reg[i][32] ? PW'(ua_reg[i][31:0]) : PW'(0));
                pl_reg[i] <= pl_full[i][63:32];
                ng_p_reg[i] <= ng_m_reg[i];
                term_reg[i].neg <= ng_p_reg[i];
                term_reg[i].mag <= (rsum[i] > PW'(ssrb_pkg::TERM_LIMIT))
                    ? ssrb_pkg::TERM_LIMIT : rsum[i][MW-1:0];
            end
        end
    end

    // Division levels: a lane with fewer divisions waits in a matching delay line.
    for (genvar ln = 0; ln < NL; ln++)
    begin : g_lvl0
        assign lvl[0][ln] = term_reg[ln];
    end

    for (genvar lv = 0; lv < ssrb_pkg::DIV_LEVELS; lv++)
    begin : g_level
        for (genvar ln = 0; ln < NL; ln++)
        begin : g_lane
            if (ssrb_pkg::LANE_DIVS[ln] > lv)
            begin : g_div
                ssrb_div u_div (
                    .clk      (clk),
                    .en       (adv),
                    .dur      (ramp_duration_reg),
                    .dividend (lvl[lv][ln]),
                    .quotient (lvl[lv+1][ln])
                );
            end
            else
            begin : g_dly
                ssrb_pkg::term_t dly_reg [ssrb_pkg::DIV_LAT];

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        dly_reg[0] <= lvl[lv][ln];
                        for (int k = 1; k < ssrb_pkg::DIV_LAT; k++)
                        begin
                            dly_reg[k] <= dly_reg[k-1];
                        end
                    end
                end

                assign lvl[lv+1][ln] = dly_reg[ssrb_pkg::DIV_LAT-1];
            end
        end
    end

    // Back to two's complement, then the sums per output.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NL; i++)
            begin
                sv_reg[i] <= lvl[ssrb_pkg::DIV_LEVELS][i].neg
                    ? -$signed({1'b0, lvl[ssrb_pkg::DIV_LEVELS][i].mag})
                    : $signed({1'b0, lvl[ssrb_pkg::DIV_LEVELS][i].mag});
            end
            pos_sum_reg <= SW'(ctx_reg[ssrb_pkg::IDX_SIGNED].tk)
                + SW'(sv_reg[ssrb_pkg::LN_POS0]);
            vel_sum_reg <= SW'(sv_reg[ssrb_pkg::LN_VEL0]) + SW'(sv_reg[ssrb_pkg::LN_VEL1]);
            acc_sum_reg <= SW'(sv_reg[ssrb_pkg::LN_ACC0]) + SW'(sv_reg[ssrb_pkg::LN_ACC1])
                + SW'(sv_reg[ssrb_pkg::LN_ACC2]);
            jerk_sum_reg <= SW'(sv_reg[ssrb_pkg::LN_JRK0]) + SW'(sv_reg[ssrb_pkg::LN_JRK1])
                + SW'(sv_reg[ssrb_pkg::LN_JRK2]) + SW'(sv_reg[ssrb_pkg::LN_JRK3]);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= vld_reg[CN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (ctx_reg[ssrb_pkg::IDX_SUM].active)
            begin
                result_reg.out_pos <= sat32(pos_sum_reg);
                result_reg.out_vel <= sat32(vel_sum_reg);
                result_reg.out_acc <= sat32(acc_sum_reg);
                result_reg.out_jerk <= sat32(jerk_sum_reg);
                result_reg.ramp_active <= 1'b1;
            end
            else
            begin
                result_reg.out_pos <= ctx_reg[ssrb_pkg::IDX_SUM].pos;
                result_reg.out_vel <= ctx_reg[ssrb_pkg::IDX_SUM].vel;
                result_reg.out_acc <= ctx_reg[ssrb_pkg::IDX_SUM].acc;
                result_reg.out_jerk <= ctx_reg[ssrb_pkg::IDX_SUM].jerk;
                result_reg.ramp_active <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule

// ===== src/ssrb_checker.sv =====
// Port-level checker for the smoothstep start-ramp blend, bound to the top level.
module ssrb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input ssrb_pkg::result_t result
);

    a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item dropped while stalled");

    a_result_stable : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result item changed while stalled");

    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input blocked while the output is empty");

    a_single_skid : assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && result_valid && !result_ready
        |=> item_ready == result_ready)
        else $error("more than one item taken while the output was stalled");

endmodule

bind smoothstep_start_ramp_blend ssrb_checker u_ssrb_checker (.*);

// ===== sim/smoothstep_start_ramp_blend_tb.sv =====
// Testbench of the smoothstep start-ramp blend: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module smoothstep_start_ramp_blend_tb;

    localparam longint BLEND_LIMIT = 64'sd549755813887;
    localparam int LATENCY = 164;
    localparam int HOLD_LEN = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    ssrb_pkg::item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    ssrb_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic [ssrb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    ssrb_pkg::item_t pending_items[$];
    ssrb_pkg::result_t expected_blends[$];
    logic [31:0] duration_q;
    logic signed [31:0] takeoff_q[3];
    int mismatch_count = 0;
    int send_idle_pct = 34;
    int recv_idle_pct = 73;
    int hold_cycles = 0;
    bit hold_armed = 1'b0;
    bit hold_used = 1'b0;
    bit item_taken = 1'b0;

    smoothstep_start_ramp_blend dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint clamp_term(longint v);
        if (v > BLEND_LIMIT)
            return BLEND_LIMIT;
        if (v < -BLEND_LIMIT)
            return -BLEND_LIMIT;
        return v;
    endfunction

    function automatic logic signed [31:0] clamp_out(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint scaled_term(longint c, longint v, int divs);
        logic [127:0] prod;
        logic [127:0] mag;
        bit neg;
        longint p;
        neg = (c < 0) != (v < 0);
        prod = 128'(c < 0 ? -c : c) * 128'(v < 0 ? -v : v);
        p = longint'(prod >> 32);
        p = clamp_term(neg ? -p : p);
        for (int i = 0; i < divs; i++)
        begin
            neg = p < 0;
            mag = (128'(neg ? -p : p) << ssrb_pkg::FRAC_BITS) / 128'(duration_q);
            if (mag > 128'(BLEND_LIMIT))
                mag = 128'(BLEND_LIMIT);
            p = neg ? -longint'(mag) : longint'(mag);
        end
        return p;
    endfunction

    function automatic ssrb_pkg::result_t blend_item(ssrb_pkg::item_t it);
        ssrb_pkg::result_t r;
        longint tk, dp, pos, vel, acc, jrk, s0, s1, s2, s3;
        logic [63:0] x, x2, x3, x4, x5;
        pos = it.nominal_pos;
        vel = it.nominal_vel;
        acc = it.nominal_acc;
        jrk = it.nominal_jerk;
        if (duration_q == 0 || it.since_start >= duration_q)
        begin
            r.out_pos = it.nominal_pos;
            r.out_vel = it.nominal_vel;
            r.out_acc = it.nominal_acc;
            r.out_jerk = it.nominal_jerk;
            r.ramp_active = 1'b0;
            return r;
        end
        tk = (it.axis == 2'd3) ? 0 : longint'(takeoff_q[it.axis]);
        dp = pos - tk;
        x = ({32'd0, it.since_start} << 32) / {32'd0, duration_q};
        x2 = (x * x) >> 32;
        x3 = (x2 * x) >> 32;
        x4 = (x3 * x) >> 32;
        x5 = (x4 * x) >> 32;
        s0 = 10 * longint'(x3) - 15 * longint'(x4) + 6 * longint'(x5);
        s1 = 30 * longint'(x2) - 60 * longint'(x3) + 30 * longint'(x4);
        s2 = 60 * longint'(x) - 180 * longint'(x2) + 120 * longint'(x3);
        s3 = 60 * (64'sd1 << 32) - 360 * longint'(x) + 360 * longint'(x2);
        r.out_pos = clamp_out(tk + scaled_term(s0, dp, 0));
        r.out_vel = clamp_out(scaled_term(s0, vel, 0) + scaled_term(s1, dp, 1));
        r.out_acc = clamp_out(scaled_term(s0, acc, 0) + scaled_term(2 * s1, vel, 1)
                              + scaled_term(s2, dp, 2));
        r.out_jerk = clamp_out(scaled_term(s0, jrk, 0) + scaled_term(3 * s1, acc, 1)
                               + scaled_term(3 * s2, vel, 2) + scaled_term(s3, dp, 3));
        r.ramp_active = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    // The expected result is predicted at the edge where the item is accepted.
    always @(posedge clk)
    begin
        item_taken <= item_valid && item_ready;
        if (rst_n && item_valid && item_ready)
        begin
            expected_blends = {expected_blends, blend_item(item)};
        end
    end

    // Driver.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_taken)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_armed && !hold_used)
            begin
                hold_used <= 1'b1;
                hold_cycles <= HOLD_LEN;
                result_ready <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                result_ready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        ssrb_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_blends.size() == 0)
            begin
                report_mismatch("unexpected result", result.out_pos, 32'd0);
            end
            else
            begin
                want = expected_blends.pop_front();
                if (result.out_pos !== want.out_pos)
                    report_mismatch("out_pos", result.out_pos, want.out_pos);
                if (result.out_vel !== want.out_vel)
                    report_mismatch("out_vel", result.out_vel, want.out_vel);
                if (result.out_acc !== want.out_acc)
                    report_mismatch("out_acc", result.out_acc, want.out_acc);
                if (result.out_jerk !== want.out_jerk)
                    report_mismatch("out_jerk", result.out_jerk, want.out_jerk);
                if (result.ramp_active !== want.ramp_active)
                    report_mismatch("ramp_active", {31'd0, result.ramp_active},
                                    {31'd0, want.ramp_active});
            end
        end
    end

    task automatic write_reg(logic [ssrb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == ssrb_pkg::REG_RAMP_DURATION)
            duration_q = val;
        else
            takeoff_q[idx - 2'd1] = val;
    endtask

    function automatic ssrb_pkg::item_t random_item(bit in_ramp);
        ssrb_pkg::item_t it;
        it.axis = 2'($urandom_range(3));
        it.nominal_pos = $urandom;
        it.nominal_vel = $urandom;
        it.nominal_acc = $urandom;
        it.nominal_jerk = $urandom;
        if ($urandom_range(3) != 0)
        begin
            it.nominal_pos = $signed($urandom_range(2000000)) - 1000000;
            it.nominal_vel = $signed($urandom_range(200000)) - 100000;
            it.nominal_acc = $signed($urandom_range(200000)) - 100000;
            it.nominal_jerk = $signed($urandom_range(200000)) - 100000;
        end
        if (in_ramp && duration_q != 0)
            it.since_start = $urandom_range(duration_q - 1);
        else
            it.since_start = $urandom;
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || item_valid || expected_blends.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic run_phase(int n, int pct_s, int pct_r);
        send_idle_pct = pct_s;
        recv_idle_pct = pct_r;
        for (int i = 0; i < n; i++)
            pending_items = {pending_items, random_item($urandom_range(4) != 0)};
        drain();
    endtask

    initial
    begin
        ssrb_pkg::item_t it;
        duration_q = ssrb_pkg::RAMP_DURATION_RESET;
        takeoff_q[0] = 0;
        takeoff_q[1] = 0;
        takeoff_q[2] = ssrb_pkg::TAKEOFF_Z_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Directed items at reset settings: extremes, every axis, ramp edges.
        for (int a = 0; a < 4; a++)
        begin
            it = '0;
            it.axis = 2'(a);
            it.since_start = 32'h8000;
            it.nominal_pos = 32'sh7fffffff;
            it.nominal_vel = 32'sh80000000;
            it.nominal_acc = 32'sh7fffffff;
            it.nominal_jerk = 32'sh80000000;
            pending_items = {pending_items, it};
            it.since_start = 0;
            it.nominal_pos = 32'sh80000000;
            it.nominal_vel = 32'sh7fffffff;
            it.nominal_acc = 32'sh80000000;
            it.nominal_jerk = 32'sh7fffffff;
            pending_items = {pending_items, it};
        end
        it.since_start = ssrb_pkg::RAMP_DURATION_RESET - 1;
        pending_items = {pending_items, it};
        it.since_start = ssrb_pkg::RAMP_DURATION_RESET;
        pending_items = {pending_items, it};
        it.since_start = 32'hffffffff;
        pending_items = {pending_items, it};
        drain();
        write_reg(ssrb_pkg::REG_RAMP_DURATION, 32'd1);
        write_reg(ssrb_pkg::REG_TAKEOFF_X, 32'h80000000);
        write_reg(ssrb_pkg::REG_TAKEOFF_Y, 32'h7fffffff);
        write_reg(ssrb_pkg::REG_TAKEOFF_Z, 32'hffffffff);
        it = '0;
        it.nominal_pos = 32'sh7fffffff;
        it.nominal_vel = 32'sh7fffffff;
        for (int a = 0; a < 4; a++)
        begin
            it.axis = 2'(a);
            pending_items = {pending_items, it};
        end
        drain();
        write_reg(ssrb_pkg::REG_RAMP_DURATION, 32'd0);
        run_phase(20, 34, 73);
        write_reg(ssrb_pkg::REG_RAMP_DURATION, 32'hffffffff);
        run_phase(60, 34, 73);
        write_reg(ssrb_pkg::REG_RAMP_DURATION, 32'h00030000);
        write_reg(ssrb_pkg::REG_TAKEOFF_X, $urandom);
        write_reg(ssrb_pkg::REG_TAKEOFF_Y, 32'h00020000);
        write_reg(ssrb_pkg::REG_TAKEOFF_Z, 32'hfff00000);
        run_phase(250, 34, 73);
        write_reg(ssrb_pkg::REG_RAMP_DURATION, 32'h00000400);
        run_phase(200, 73, 34);
        write_reg(ssrb_pkg::REG_RAMP_DURATION, $urandom);
        hold_armed = 1'b1;
        run_phase(270, 0, 0);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/ssrb_pkg.sv
src/ssrb_div.sv
src/smoothstep_start_ramp_blend.sv
src/ssrb_checker.sv
sim/smoothstep_start_ramp_blend_tb.sv
